[rtl/efe_pkg.sv]
// ----------------------------------------------------------------------------
// efe_pkg: shared types, constants and functions of the framing encoder
// Holds the code register indexes and reset values, the code set struct,
// the result sequence struct, the CRC-8 byte update and the escape check.
// ----------------------------------------------------------------------------
package efe_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_START_CODE  = 2'd0;
    localparam logic [1:0] CFG_END_CODE    = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_CODE = 2'd2;

    // code values after reset
    localparam logic [7:0] START_CODE_RST  = 8'd2;
    localparam logic [7:0] END_CODE_RST    = 8'd23;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'd27;

    // CRC-8, MSB first
    localparam logic [7:0] CRC_POLY        = 8'h07;

    // longest burst of line bytes for one payload byte
    localparam int unsigned SEQ_MAX        = 7;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } t_codes;

    // line bytes for one payload byte, entry 0 goes out first
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    ends_frame;
    } t_seq;

    // one byte through the CRC register, bit by bit
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // byte collides with one of the reserved codes
    function automatic logic needs_escape(input logic [7:0] b, input t_codes codes);
        return (b == codes.escape_code) || (b == codes.start_code) || (b == codes.end_code);
    endfunction

endpackage

[rtl/efe_cfg_regs.sv]
// ----------------------------------------------------------------------------
// efe_cfg_regs: frame code registers
// Start, end and escape code values, written through the plain write port.
// ----------------------------------------------------------------------------
module efe_cfg_regs import efe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    output t_codes     o_codes
);

    t_codes r_codes;

    // indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.start_code  <= START_CODE_RST;
            r_codes.end_code    <= END_CODE_RST;
            r_codes.escape_code <= ESCAPE_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_CODE:  r_codes.start_code  <= i_cfg_wdata;
                CFG_END_CODE:    r_codes.end_code    <= i_cfg_wdata;
                CFG_ESCAPE_CODE: r_codes.escape_code <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_codes = r_codes;

endmodule

[rtl/efe_frame_build.sv]
// ----------------------------------------------------------------------------
// efe_frame_build: input register, running CRC and line sequence builder
// Holds one payload byte and turns it into its burst of line bytes: start
// codes, escapes, the byte itself, and at frame end the CRC and end code.
// ----------------------------------------------------------------------------
module efe_frame_build import efe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_codes     i_codes,
    // payload side
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_first,
    input  logic       i_in_last,
    // sequence towards the output stage
    input  logic       i_load_ok,
    output logic       o_load,
    output t_seq       o_seq
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_first;
    logic       r_last;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic       load;
    t_seq       seq;

    assign load       = r_valid && i_load_ok;
    assign o_in_ready = !r_valid || load;

    // input register: refilled as soon as its byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte  <= i_in_byte;
            r_first <= i_in_first;
            r_last  <= i_in_last;
        end
    end

    // running CRC, cleared by a first mark
    assign n_crc = crc8_update(r_first ? 8'h00 : r_crc, r_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 8'h00;
        end else if (load) begin
            r_crc <= n_crc;
        end
    end

    // pack the burst of line bytes in transmit order
    always_comb begin
        logic [2:0] pos;
        pos            = 3'd0;
        seq.bytes      = '0;
        seq.ends_frame = r_last;
        if (r_first) begin
            seq.bytes[pos] = i_codes.start_code;
            pos            = pos + 3'd1;
            seq.bytes[pos] = i_codes.start_code;
            pos            = pos + 3'd1;
        end
        if (needs_escape(r_byte, i_codes)) begin
            seq.bytes[pos] = i_codes.escape_code;
            pos            = pos + 3'd1;
        end
        seq.bytes[pos] = r_byte;
        pos            = pos + 3'd1;
        if (r_last) begin
            if (needs_escape(n_crc, i_codes)) begin
                seq.bytes[pos] = i_codes.escape_code;
                pos            = pos + 3'd1;
            end
            seq.bytes[pos] = n_crc;
            pos            = pos + 3'd1;
            seq.bytes[pos] = i_codes.end_code;
            pos            = pos + 3'd1;
        end
        seq.cnt = pos;
    end

    assign o_load = load;
    assign o_seq  = seq;

endmodule

[rtl/efe_byte_out.sv]
// ----------------------------------------------------------------------------
// efe_byte_out: line byte shifter and output register
// Holds one burst of line bytes and sends it one byte per transfer; the
// next burst is taken in while the final byte of this one leaves.
// ----------------------------------------------------------------------------
module efe_byte_out import efe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_seq       i_seq,
    output logic       o_load_ok,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_run_end,
    output logic       o_frame_end
);

    logic [SEQ_MAX-1:0][7:0] r_bytes;
    logic [2:0]              r_cnt;
    logic                    r_ends_frame;
    logic                    xfer;
    logic                    final_byte;

    assign xfer       = (r_cnt != 3'd0) && i_ready;
    assign final_byte = (r_cnt == 3'd1);
    assign o_load_ok  = (r_cnt == 3'd0) || (final_byte && i_ready);

    // byte count of the current burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_seq.cnt;
        end else if (xfer) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // burst bytes, shifted towards entry 0 on each transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes      <= i_seq.bytes;
            r_ends_frame <= i_seq.ends_frame;
        end else if (xfer) begin
            r_bytes <= {8'h00, r_bytes[SEQ_MAX-1:1]};
        end
    end

    assign o_valid     = (r_cnt != 3'd0);
    assign o_byte      = r_bytes[0];
    assign o_run_end   = final_byte;
    assign o_frame_end = final_byte && r_ends_frame;

endmodule

[rtl/escaped_frame_encoder_crc8_core.sv]
// ----------------------------------------------------------------------------
// escaped_frame_encoder_crc8_core: byte-stuffed frame encoder with CRC-8
// A payload byte passes the input register, then the output byte shifter.
// Up to one line byte per cycle, held while the line side is not ready; a
// payload byte causes 1 to 7 line bytes, sent by the single byte shifter.
// Reset (synchronous, active low): empties both stages, clears the CRC and
// loads the code registers with start 2, end 23, escape 27.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_crc8_core import efe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // code register write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    // payload stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] payload_byte
    input  logic       i_s_tuser,   // [0] first_of_frame
    input  logic       i_s_tlast,   // last_of_frame
    // line stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] line_byte
    output logic       o_m_tuser,   // [0] frame_end
    output logic       o_m_tlast    // run_end
);

    t_codes codes;
    t_seq   seq;
    logic   load;
    logic   load_ok;

    efe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_codes     (codes)
    );

    efe_frame_build u_build (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_codes    (codes),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_in_byte  (i_s_tdata),
        .i_in_first (i_s_tuser),
        .i_in_last  (i_s_tlast),
        .i_load_ok  (load_ok),
        .o_load     (load),
        .o_seq      (seq)
    );

    efe_byte_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_seq       (seq),
        .o_load_ok   (load_ok),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_byte      (o_m_tdata),
        .o_run_end   (o_m_tlast),
        .o_frame_end (o_m_tuser)
    );

endmodule
